// ----- rtl/figure_eight_trajectory_sample_macros.svh -----
// ---------------------------------------------------------------------------
// figure eight sample macros
// assertion shorthands used by the trajectory sample rtl
// ---------------------------------------------------------------------------
`ifndef FIGURE_EIGHT_TRAJECTORY_SAMPLE_MACROS_SVH
`define FIGURE_EIGHT_TRAJECTORY_SAMPLE_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define FE8_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk, off during rst
`define FE8_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/fe8_pkg.sv -----
// ---------------------------------------------------------------------------
// fe8_pkg
// types, constants and the arctangent table of the figure eight sampler
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package fe8_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 16;

  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [1:0] {
    CFG_PHASE_STEP = 2'd0,
    CFG_AMPLITUDE  = 2'd1,
    CFG_SPEED_GAIN = 2'd2,
    CFG_ACCEL_GAIN = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
    logic [1:0]         quad;
  } cordic_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sqrt_t;

  typedef struct packed {
    logic [47:0] rem;
    logic [31:0] m;
    logic [15:0] q;
  } div_t;

  typedef struct packed {
    logic signed [16:0] px;
    logic signed [16:0] py;
    logic signed [16:0] vx;
    logic signed [16:0] vy;
    logic signed [16:0] ax;
    logic signed [16:0] ay;
    logic [16:0]        magx;
    logic [16:0]        magy;
    logic               sx;
    logic               sy;
    logic               dvalid;
    logic               last;
  } kin_t;

  // atan(2^-i) in turns scaled by 2^32
  function automatic logic [31:0] atan_turns(input int i);
    case (i)
      0:  return 32'h20000000;
      1:  return 32'h12E4051D;
      2:  return 32'h09FB385B;
      3:  return 32'h051111D4;
      4:  return 32'h028B0D43;
      5:  return 32'h0145D7E1;
      6:  return 32'h00A2F61E;
      7:  return 32'h00517C55;
      8:  return 32'h0028BE53;
      9:  return 32'h00145F2E;
      10: return 32'h000A2F98;
      11: return 32'h000517CC;
      12: return 32'h00028BE6;
      13: return 32'h000145F3;
      14: return 32'h0000A2F9;
      15: return 32'h0000517C;
      16: return 32'h000028BE;
      17: return 32'h0000145F;
      18: return 32'h00000A2F;
      19: return 32'h00000517;
      20: return 32'h0000028B;
      21: return 32'h00000145;
      22: return 32'h000000A2;
      23: return 32'h00000051;
      default: return 32'h00000000;
    endcase
  endfunction

endpackage

// ----- rtl/fe8_cordic_cell.sv -----
// ---------------------------------------------------------------------------
// fe8_cordic_cell
// one rotation step of the sin/cos chain
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fe8_cordic_cell import fe8_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic    clk,
  input  logic    en,
  input  cordic_t din,
  output cordic_t dout
);

  cordic_t nxt;
  logic signed [32:0] ang;

  always_comb begin
    ang = $signed({1'b0, atan_turns(STAGE)});
    nxt = din;
    if (!din.z[32]) begin
      nxt.x = din.x - (din.y >>> STAGE);
      nxt.y = din.y + (din.x >>> STAGE);
      nxt.z = din.z - ang;
    end else begin
      nxt.x = din.x + (din.y >>> STAGE);
      nxt.y = din.y - (din.x >>> STAGE);
      nxt.z = din.z + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ----- rtl/fe8_sqrt_cell.sv -----
// ---------------------------------------------------------------------------
// fe8_sqrt_cell
// one root bit of the integer square root chain
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fe8_sqrt_cell import fe8_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  logic  en,
  input  sqrt_t din,
  output sqrt_t dout
);

  localparam logic [63:0] BIT = 64'(1) << (62 - 2 * STEP);

  sqrt_t nxt;
  logic [63:0] trial;

  always_comb begin
    trial = din.r + BIT;
    nxt = din;
    if (din.n >= trial) begin
      nxt.n = din.n - trial;
      nxt.r = (din.r >> 1) + BIT;
    end else begin
      nxt.r = din.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ----- rtl/fe8_div_cell.sv -----
// ---------------------------------------------------------------------------
// fe8_div_cell
// one quotient bit of the restoring divider chain
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module fe8_div_cell import fe8_pkg::*; #(
  parameter int BIT = 15
) (
  input  logic clk,
  input  logic en,
  input  div_t din,
  output div_t dout
);

  div_t nxt;
  logic [47:0] den;

  always_comb begin
    den = 48'(din.m) << BIT;
    nxt = din;
    if (din.rem >= den) begin
      nxt.rem    = din.rem - den;
      nxt.q[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ----- rtl/figure_eight_trajectory_sample.sv -----
// ---------------------------------------------------------------------------
// figure_eight_trajectory_sample
// Input words carry a sample index (s_axis_tdata). Each gives one output
// word: position, velocity, acceleration, unit tangent and normal of a
// 1:2 figure eight (m_axis_tdata), direction valid flag (m_axis_tuser)
// and end of period mark (m_axis_tlast).
// The user must write registers over cfg_we / cfg_index / cfg_data only
// while idle; the block itself does not enforce it. The pipeline from
// input acceptance to tvalid holds the index multiply, the CORDIC cell
// row, gain products, a 32 cell square root row and a 16 cell divider
// row, one register each. Throughput is one word per cycle; the whole
// pipeline moves whenever the output register is empty or being taken.
// When the receiver stalls, every stage holds and s_axis_tready drops in
// the same cycle, so nothing is lost.
// Reset restores the register defaults and empties the pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "figure_eight_trajectory_sample_macros.svh"

module figure_eight_trajectory_sample import fe8_pkg::*; #(
  parameter int INDEX_BITS    = 20,
  parameter int CORDIC_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [23:0]  s_axis_tdata,  // sample_index[19:0], zero pad
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // pos_x, pos_y, vel_x, vel_y, acc_x, acc_y (17 each),
  // tangent_x, tangent_y, normal_x, normal_y (16 each), zero pad
  output logic [167:0] m_axis_tdata,
  output logic         m_axis_tuser,  // direction_valid
  output logic         m_axis_tlast,  // last_of_period
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  localparam int CS = CORDIC_STAGES;

  typedef enum logic [1:0] {
    RND_Q30,
    RND_Q31,
    RND_NEG_Q30,
    RND_NEG_Q32
  } rnd_t;

  logic [31:0] phase_step;
  logic [15:0] amplitude, speed_gain, accel_gain;
  logic        adv;

  logic                  a_vld, b_vld, c_vld, d_vld, e_vld, f_vld, g_vld;
  logic [INDEX_BITS-1:0] a_idx;
  logic [31:0]           idx_ext;
  logic [63:0]           b_prod;
  logic [32:0]           wrap_sum;
  logic [31:0]           c_p1;
  logic                  c_last, d_last;

  cordic_t cd1 [CS+1];
  cordic_t cd2 [CS+1];
  logic    cd_vld  [CS];
  logic    cd_last [CS];

  logic signed [31:0] s1, c1, s2, c2;
  kin_t        e_kin, f_kin, g_kin;
  kin_t        e_nxt, f_nxt;
  logic [33:0] f_n2;

  sqrt_t sq [SQRT_STEPS+1];
  kin_t  sq_kin [SQRT_STEPS];
  logic  sq_vld [SQRT_STEPS];

  div_t dvx [DIV_STEPS+1];
  div_t dvy [DIV_STEPS+1];
  div_t dx0, dy0;
  kin_t dv_kin [DIV_STEPS];
  logic dv_vld [DIV_STEPS];

  kin_t               ok;
  logic signed [15:0] tx, ty, nx, ny;

  function automatic logic signed [31:0] clamp30(input logic signed [33:0] v);
    if (v > 34'sd1073741824) begin
      return 32'sd1073741824;
    end else if (v < -34'sd1073741824) begin
      return -32'sd1073741824;
    end
    return 32'(v);
  endfunction

  function automatic logic signed [31:0] trig_sel(input logic [1:0] q,
                                                  input logic signed [31:0] x,
                                                  input logic signed [31:0] y,
                                                  input logic is_sin);
    case (q)
      2'd0:    return is_sin ? y : x;
      2'd1:    return is_sin ? x : -y;
      2'd2:    return is_sin ? -y : -x;
      default: return is_sin ? -x : y;
    endcase
  endfunction

  function automatic logic signed [16:0] scale(input logic [15:0] g,
                                               input logic signed [31:0] t,
                                               input rnd_t mode);
    logic signed [49:0] p;
    logic signed [49:0] r;
    p = $signed({1'b0, g}) * t;
    case (mode)
      RND_Q30: begin
        r = p + 50'sd536870912;
        return r[46:30];
      end
      RND_Q31: begin
        r = p + 50'sd1073741824;
        return r[47:31];
      end
      RND_NEG_Q30: begin
        r = 50'sd536870912 - p;
        return r[46:30];
      end
      default: begin
        r = 50'sd2147483648 - p;
        return r[48:32];
      end
    endcase
  endfunction

  function automatic logic signed [15:0] unit(input logic [15:0] q, input logic neg);
    logic signed [16:0] nq;
    nq = -$signed({1'b0, q});
    if (neg) begin
      return nq[15:0];
    end
    return (q > 16'd32767) ? 16'sd32767 : $signed(q);
  endfunction

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= 32'd4294967;
      amplitude  <= 16'd256;
      speed_gain <= 16'd256;
      accel_gain <= 16'd256;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PHASE_STEP: phase_step <= cfg_data;
        CFG_AMPLITUDE:  amplitude  <= cfg_data[15:0];
        CFG_SPEED_GAIN: speed_gain <= cfg_data[15:0];
        CFG_ACCEL_GAIN: accel_gain <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // index, phase and end of period
  assign idx_ext  = 32'(s_axis_tdata[19:0]);
  assign wrap_sum = 33'(b_prod[31:0]) + 33'(phase_step);

  always_ff @(posedge clk) begin
    if (adv) begin
      a_idx  <= idx_ext[INDEX_BITS-1:0];
      b_prod <= 64'(a_idx) * 64'(phase_step);
      c_p1   <= b_prod[31:0];
      c_last <= (b_prod[63:32] == 32'd0) && wrap_sum[32];
    end
  end

  // cordic rows for the phase and twice the phase
  assign cd1[0].x    = CORDIC_X0;
  assign cd1[0].y    = '0;
  assign cd1[0].z    = {3'b000, c_p1[29:0]};
  assign cd1[0].quad = c_p1[31:30];
  assign cd2[0].x    = CORDIC_X0;
  assign cd2[0].y    = '0;
  assign cd2[0].z    = {3'b000, c_p1[28:0], 1'b0};
  assign cd2[0].quad = c_p1[30:29];

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    fe8_cordic_cell #(.STAGE(k)) u_c1 (.clk(clk), .en(adv), .din(cd1[k]), .dout(cd1[k+1]));
    fe8_cordic_cell #(.STAGE(k)) u_c2 (.clk(clk), .en(adv), .din(cd2[k]), .dout(cd2[k+1]));
  end

  // gain products and speed magnitudes
  always_comb begin
    e_nxt      = '0;
    e_nxt.px   = scale(amplitude, s1, RND_Q30);
    e_nxt.py   = scale(amplitude, s2, RND_Q30);
    e_nxt.vx   = scale(speed_gain, c1, RND_Q31);
    e_nxt.vy   = scale(speed_gain, c2, RND_Q30);
    e_nxt.ax   = scale(accel_gain, s1, RND_NEG_Q32);
    e_nxt.ay   = scale(accel_gain, s2, RND_NEG_Q30);
    e_nxt.last = d_last;

    f_nxt        = e_kin;
    f_nxt.sx     = e_kin.vx[16];
    f_nxt.sy     = e_kin.vy[16];
    f_nxt.magx   = e_kin.vx[16] ? 17'(-e_kin.vx) : 17'(e_kin.vx);
    f_nxt.magy   = e_kin.vy[16] ? 17'(-e_kin.vy) : 17'(e_kin.vy);
    f_nxt.dvalid = (e_kin.vx != 17'sd0) || (e_kin.vy != 17'sd0);
  end

  // trig, gain products, squared speed
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < CS; k++) begin
        cd_last[k] <= (k == 0) ? c_last : cd_last[(k == 0) ? 0 : k - 1];
      end
      d_last <= cd_last[CS-1];
      s1 <= trig_sel(cd1[CS].quad, clamp30(cd1[CS].x), clamp30(cd1[CS].y), 1'b1);
      c1 <= trig_sel(cd1[CS].quad, clamp30(cd1[CS].x), clamp30(cd1[CS].y), 1'b0);
      s2 <= trig_sel(cd2[CS].quad, clamp30(cd2[CS].x), clamp30(cd2[CS].y), 1'b1);
      c2 <= trig_sel(cd2[CS].quad, clamp30(cd2[CS].x), clamp30(cd2[CS].y), 1'b0);

      e_kin <= e_nxt;
      f_kin <= f_nxt;
      f_n2  <= 34'(e_kin.vx * e_kin.vx) + 34'(e_kin.vy * e_kin.vy);
    end
  end

  // square root row, magnitude of the velocity scaled by 2^15
  assign sq[0].n = {f_n2, 30'd0};
  assign sq[0].r = '0;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    fe8_sqrt_cell #(.STEP(k)) u_sq (.clk(clk), .en(adv), .din(sq[k]), .dout(sq[k+1]));
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_kin[0] <= f_kin;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq_kin[k] <= sq_kin[k-1];
      end
      g_kin     <= sq_kin[SQRT_STEPS-1];
      dx0.rem   <= (48'(sq_kin[SQRT_STEPS-1].magx) << 30) + 48'(sq[SQRT_STEPS].r[31:1]);
      dy0.rem   <= (48'(sq_kin[SQRT_STEPS-1].magy) << 30) + 48'(sq[SQRT_STEPS].r[31:1]);
      dx0.m     <= sq[SQRT_STEPS].r[31:0];
      dy0.m     <= sq[SQRT_STEPS].r[31:0];
      dx0.q     <= '0;
      dy0.q     <= '0;
      dv_kin[0] <= g_kin;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_kin[k] <= dv_kin[k-1];
      end
    end
  end

  assign dvx[0] = dx0;
  assign dvy[0] = dy0;

  // divider rows, one per tangent component
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    fe8_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_dx (
      .clk(clk), .en(adv), .din(dvx[k]), .dout(dvx[k+1]));
    fe8_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_dy (
      .clk(clk), .en(adv), .din(dvy[k]), .dout(dvy[k+1]));
  end

  // output formatting
  assign ok = dv_kin[DIV_STEPS-1];

  always_comb begin
    tx = '0;
    ty = '0;
    nx = '0;
    ny = '0;
    if (ok.dvalid) begin
      tx = unit(dvx[DIV_STEPS].q, ok.sx);
      ty = unit(dvy[DIV_STEPS].q, ok.sy);
      nx = (ty == -16'sd32768) ? 16'sd32767 : -ty;
      ny = tx;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_axis_tdata <= {2'b00, ny, nx, ty, tx, ok.ay, ok.ax, ok.vy, ok.vx, ok.py, ok.px};
      m_axis_tuser <= ok.dvalid;
      m_axis_tlast <= ok.last;
    end
  end

  // word valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld         <= 1'b0;
      b_vld         <= 1'b0;
      c_vld         <= 1'b0;
      d_vld         <= 1'b0;
      e_vld         <= 1'b0;
      f_vld         <= 1'b0;
      g_vld         <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k < CS; k++) begin
        cd_vld[k] <= 1'b0;
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sq_vld[k] <= 1'b0;
      end
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_vld[k] <= 1'b0;
      end
    end else if (adv) begin
      a_vld     <= s_axis_tvalid;
      b_vld     <= a_vld;
      c_vld     <= b_vld;
      cd_vld[0] <= c_vld;
      for (int k = 1; k < CS; k++) begin
        cd_vld[k] <= cd_vld[k-1];
      end
      d_vld     <= cd_vld[CS-1];
      e_vld     <= d_vld;
      f_vld     <= e_vld;
      sq_vld[0] <= f_vld;
      for (int k = 1; k < SQRT_STEPS; k++) begin
        sq_vld[k] <= sq_vld[k-1];
      end
      g_vld     <= sq_vld[SQRT_STEPS-1];
      dv_vld[0] <= g_vld;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_vld[k] <= dv_vld[k-1];
      end
      m_axis_tvalid <= dv_vld[DIV_STEPS-1];
    end
  end

  `FE8_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, a_vld, "accepted word not in pipeline")
  `FE8_ASSERT_NXT(a_tail_to_out, dv_vld[DIV_STEPS-1] && adv, m_axis_tvalid, "finished word not presented")
  `FE8_ASSERT_IMP(a_normal_y, m_axis_tvalid, m_axis_tdata[165:150] == m_axis_tdata[117:102], "normal y differs from tangent x")
  `FE8_ASSERT_IMP(a_no_dir, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[165:102] == 64'd0, "direction set at zero speed")

endmodule
